// ----- rtl/tga_pkg.sv -----
`timescale 1ns / 1ps

package tga_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PACKET,
    PH_PIXEL,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_HI,
    DIV_LO
  } div_state_e;

  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_TYPE   = 2'd1;
  localparam logic [1:0] ERR_FORMAT = 2'd2;

  localparam logic [7:0] TYPE_RAW       = 8'd2;
  localparam logic [7:0] TYPE_RLE       = 8'd10;
  localparam logic [7:0] DEPTH_24       = 8'd24;
  localparam logic [7:0] DEPTH_32       = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;
  localparam logic [7:0] RLE_COUNT_MASK = 8'h7f;

  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_CMAP      = 5'd1;
  localparam logic [4:0] HDR_TYPE      = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } byte_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] start_column;
    logic [15:0] start_row;
    logic [7:0]  run_count;
    logic        image_done;
  } run_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       cancel;
    logic [7:0] n;
  } pos_ctl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [7:0]  cnt;
    logic [15:0] col;
    logic [15:0] row;
  } pos_stat_t;

endpackage

// ----- rtl/tga_if.sv -----
`timescale 1ns / 1ps

interface tga_byte_if;
  import tga_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tga_run_if;
  import tga_pkg::*;
  logic valid;
  logic ready;
  run_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/tga_pos_track.sv -----
`timescale 1ns / 1ps

module tga_pos_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tga_pkg::pos_ctl_t   ctl_i,
  input  logic [15:0]         width_i,
  input  logic [15:0]         height_i,
  output tga_pkg::pos_stat_t  stat_o
);
  import tga_pkg::*;

  localparam int unsigned DivStepsPerCycle = 4;

  div_state_e  st_q, st_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [16:0] work_q, work_d;
  logic [7:0]  quo_q, quo_d;

  logic        done;
  logic [7:0]  cnt;
  logic [16:0] work;
  logic [7:0]  quo;
  logic [2:0]  bit_idx;
  logic [23:0] dvs;
  logic [31:0] area;

  assign done = rem_q <= {24'd0, ctl_i.n};
  assign cnt  = done ? rem_q[7:0] : ctl_i.n;
  assign area = {16'd0, width_i} * {16'd0, height_i};

  // restoring divide of column + count by width, four quotient bits a cycle
  always_comb begin
    work    = work_q;
    quo     = quo_q;
    bit_idx = '0;
    dvs     = '0;
    for (int k = 0; k < DivStepsPerCycle; k++) begin
      bit_idx = {(st_q == DIV_HI), 2'(3 - k)};
      dvs     = {8'd0, width_i} << bit_idx;
      if ({7'd0, work} >= dvs) begin
        work         = work - dvs[16:0];
        quo[bit_idx] = 1'b1;
      end
    end
  end

  always_comb begin
    st_d   = st_q;
    rem_d  = rem_q;
    col_d  = col_q;
    row_d  = row_q;
    work_d = work_q;
    quo_d  = quo_q;
    case (st_q)
      DIV_HI: begin
        work_d = work;
        quo_d  = quo;
        st_d   = DIV_LO;
      end
      DIV_LO: begin
        col_d = work[15:0];
        row_d = row_q - {8'd0, quo};
        st_d  = DIV_IDLE;
      end
      default: ;
    endcase
    if (ctl_i.emit && !done) begin
      rem_d  = rem_q - {24'd0, cnt};
      work_d = {1'b0, col_q} + {9'd0, cnt};
      quo_d  = '0;
      st_d   = DIV_HI;
    end
    if (ctl_i.load) begin
      rem_d = area;
      row_d = height_i - 16'd1;
      col_d = '0;
      st_d  = DIV_IDLE;
    end
    if (ctl_i.cancel) begin
      st_d = DIV_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= DIV_IDLE;
      rem_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      st_q  <= st_d;
      rem_q <= rem_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    quo_q  <= quo_d;
  end

  assign stat_o.busy = st_q != DIV_IDLE;
  assign stat_o.done = done;
  assign stat_o.cnt  = cnt;
  assign stat_o.col  = col_q;
  assign stat_o.row  = row_q;

endmodule

// ----- rtl/tga_parser.sv -----
`timescale 1ns / 1ps

module tga_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_acc_i,
  input  tga_pkg::byte_t      in_data_i,
  input  tga_pkg::pos_stat_t  pos_i,
  output tga_pkg::pos_ctl_t   pos_o,
  output logic [15:0]         width_o,
  output logic [15:0]         height_o,
  output logic                res_valid_o,
  output tga_pkg::run_t       res_o
);
  import tga_pkg::*;

  phase_e      phase_q, phase_d, e_phase;
  logic [4:0]  idx_q, idx_d, e_idx;
  logic [7:0]  id_q, id_d, e_id;
  logic [7:0]  cmap_q, cmap_d, e_cmap;
  logic [7:0]  type_q, type_d, e_type;
  logic [15:0] width_q, width_d, e_width;
  logic [15:0] height_q, height_d, e_height;
  logic [7:0]  depth_q, depth_d, e_depth;
  logic [7:0]  skip_q, skip_d, e_skip;
  logic [7:0]  pleft_q, pleft_d, e_pleft;
  logic        run_q, run_d, e_run;
  logic [1:0]  bip_q, bip_d, e_bip;
  logic [31:0] hold_q, hold_d, e_hold;

  logic        sof;
  logic [7:0]  b;
  logic [1:0]  last_bip;
  logic [31:0] color;
  logic        bad_type;
  logic        bad_fmt;

  assign sof = in_data_i.start_of_file;
  assign b   = in_data_i.byte_value;

  // start of file clears the parser before this byte is parsed
  always_comb begin
    e_phase  = sof ? PH_HEADER : phase_q;
    e_idx    = sof ? '0 : idx_q;
    e_id     = sof ? '0 : id_q;
    e_cmap   = sof ? '0 : cmap_q;
    e_type   = sof ? '0 : type_q;
    e_width  = sof ? '0 : width_q;
    e_height = sof ? '0 : height_q;
    e_depth  = sof ? '0 : depth_q;
    e_skip   = sof ? '0 : skip_q;
    e_pleft  = sof ? '0 : pleft_q;
    e_run    = sof ? '0 : run_q;
    e_bip    = sof ? '0 : bip_q;
    e_hold   = sof ? '0 : hold_q;
  end

  assign last_bip = (e_depth == DEPTH_32) ? 2'd3 : 2'd2;
  assign color    = ((e_bip == 2'd0) ? 32'd0 : e_hold) | (32'(b) << {e_bip, 3'b000});
  assign bad_type = (e_type != TYPE_RAW) && (e_type != TYPE_RLE);
  assign bad_fmt  = (e_cmap != 8'd0) || ((e_depth != DEPTH_24) && (e_depth != DEPTH_32));

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    id_d        = id_q;
    cmap_d      = cmap_q;
    type_d      = type_q;
    width_d     = width_q;
    height_d    = height_q;
    depth_d     = depth_q;
    skip_d      = skip_q;
    pleft_d     = pleft_q;
    run_d       = run_q;
    bip_d       = bip_q;
    hold_d      = hold_q;
    pos_o       = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (in_acc_i) begin
      phase_d      = e_phase;
      idx_d        = e_idx;
      id_d         = e_id;
      cmap_d       = e_cmap;
      type_d       = e_type;
      width_d      = e_width;
      height_d     = e_height;
      depth_d      = e_depth;
      skip_d       = e_skip;
      pleft_d      = e_pleft;
      run_d        = e_run;
      bip_d        = e_bip;
      hold_d       = e_hold;
      pos_o.cancel = sof;
      case (e_phase)
        PH_HEADER: begin
          idx_d = e_idx + 5'd1;
          case (e_idx)
            HDR_ID_LEN:    id_d = b;
            HDR_CMAP:      cmap_d = b;
            HDR_TYPE:      type_d = b;
            HDR_WIDTH_LO:  width_d = {e_width[15:8], b};
            HDR_WIDTH_HI:  width_d = {b, e_width[7:0]};
            HDR_HEIGHT_LO: height_d = {e_height[15:8], b};
            HDR_HEIGHT_HI: height_d = {b, e_height[7:0]};
            HDR_DEPTH:     depth_d = b;
            default: ;
          endcase
          if (e_idx == HDR_LAST) begin
            if (bad_type || bad_fmt) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = bad_type ? ERR_TYPE : ERR_FORMAT;
              phase_d          = PH_STOP;
            end else if ((e_width == 16'd0) || (e_height == 16'd0)) begin
              phase_d = PH_STOP;
            end else begin
              pos_o.load = 1'b1;
              if (e_id != 8'd0) begin
                skip_d  = e_id;
                phase_d = PH_SKIP;
              end else begin
                bip_d   = '0;
                pleft_d = '0;
                run_d   = 1'b0;
                phase_d = (e_type == TYPE_RLE) ? PH_PACKET : PH_PIXEL;
              end
            end
          end
        end
        PH_SKIP: begin
          skip_d = e_skip - 8'd1;
          if (e_skip == 8'd1) begin
            bip_d   = '0;
            pleft_d = '0;
            run_d   = 1'b0;
            phase_d = (e_type == TYPE_RLE) ? PH_PACKET : PH_PIXEL;
          end
        end
        PH_PACKET: begin
          pleft_d = (b & RLE_COUNT_MASK) + 8'd1;
          run_d   = b[7];
          bip_d   = '0;
          phase_d = PH_PIXEL;
        end
        PH_PIXEL: begin
          hold_d = color;
          if (e_bip != last_bip) begin
            bip_d = e_bip + 2'd1;
          end else begin
            bip_d   = '0;
            pos_o.n = 8'd1;
            if (e_type == TYPE_RLE) begin
              if (e_run) begin
                pos_o.n = e_pleft;
                pleft_d = '0;
              end else begin
                pleft_d = e_pleft - 8'd1;
              end
            end
            pos_o.emit         = 1'b1;
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_RUN;
            res_o.error_code   = ERR_NONE;
            res_o.red          = color[23:16];
            res_o.green        = color[15:8];
            res_o.blue         = color[7:0];
            res_o.alpha        = (e_depth == DEPTH_24) ? ALPHA_OPAQUE : color[31:24];
            res_o.start_column = pos_i.col;
            res_o.start_row    = pos_i.row;
            res_o.run_count    = pos_i.cnt;
            res_o.image_done   = pos_i.done;
            if (pos_i.done) begin
              phase_d = PH_STOP;
            end else if ((e_type == TYPE_RLE) && (pleft_d == 8'd0)) begin
              phase_d = PH_PACKET;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      idx_q    <= '0;
      id_q     <= '0;
      cmap_q   <= '0;
      type_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      skip_q   <= '0;
      pleft_q  <= '0;
      run_q    <= 1'b0;
      bip_q    <= '0;
      hold_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      id_q     <= id_d;
      cmap_q   <= cmap_d;
      type_q   <= type_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      skip_q   <= skip_d;
      pleft_q  <= pleft_d;
      run_q    <= run_d;
      bip_q    <= bip_d;
      hold_q   <= hold_d;
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

// ----- rtl/tga_out_skid.sv -----
`timescale 1ns / 1ps

module tga_out_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tga_pkg::run_t  push_data_i,
  output logic           ready_o,
  output logic           out_valid_o,
  output tga_pkg::run_t  out_data_o,
  input  logic           out_ready_i
);
  import tga_pkg::*;

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  run_t main_q, main_d;
  run_t skid_q, skid_d;
  logic pop;

  assign pop = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_valid_q && !pop) begin
      if (push_i) begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end else if (skid_valid_q) begin
      main_valid_d = 1'b1;
      main_d       = skid_q;
      skid_valid_d = push_i;
      skid_d       = push_data_i;
    end else begin
      main_valid_d = push_i;
      main_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

endmodule

// ----- rtl/tga_image_stream_decoder.sv -----
`timescale 1ns / 1ps

// TGA byte stream decoder for 24/32-bit raw (type 2) and RLE (type 10) images.
// in_i  : one file byte per transaction; start_of_file restarts the parser
//         on that byte, which is taken as header byte 0.
// out_o : one transaction per decoded pixel or RLE run (RGBA, start column,
//         destination row counting down from height-1, run count, done flag),
//         or one error transaction for an unsupported header.
// A result is registered in the output buffer before it is valid on out_o.
// Throughput: one byte per cycle while in_i.ready is high. Results come
// at most every third byte; the row/column update after a run is a
// four-bit-per-cycle divide by the image width that finishes within the
// next pixel's bytes.
// Reset: parser waits for header byte 0, the output buffer is empty.
// Stall: results sit in a two-entry output buffer; in_i.ready drops only
// while both entries are full and returns once out_o takes one.
// After an error, an empty image or the last pixel, bytes are consumed and
// dropped until the next start_of_file.
module tga_image_stream_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  tga_byte_if.sink     in_i,
  tga_run_if.source    out_o
);
  import tga_pkg::*;

  logic        in_ready;
  logic        in_acc;
  logic        res_valid;
  run_t        res;
  pos_ctl_t    pos_ctl;
  pos_stat_t   pos_stat;
  logic [15:0] width;
  logic [15:0] height;

  assign in_acc     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  tga_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .in_data_i   (in_i.data),
    .pos_i       (pos_stat),
    .pos_o       (pos_ctl),
    .width_o     (width),
    .height_o    (height),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tga_pos_track u_pos_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (pos_ctl),
    .width_i  (width),
    .height_i (height),
    .stat_o   (pos_stat)
  );

  tga_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (in_ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

  a_emit_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_ctl.emit |-> !pos_stat.busy)
    else $error("run emitted while position update in flight");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty output register");

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.data.kind == KIND_RUN)) |-> (out_o.data.run_count != 8'd0))
    else $error("pixel run with zero count");

  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.data.kind == KIND_ERROR)) |->
      (out_o.data.error_code != ERR_NONE && out_o.data.run_count == 8'd0))
    else $error("malformed error result");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tga_pkg::*;

  logic clk_i;
  logic rst_ni;

  tga_byte_if in_if ();
  tga_run_if  out_if ();

  tga_image_stream_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // decoder model state
  phase_e      dec_phase;
  logic [4:0]  hdr_idx;
  logic [7:0]  id_len;
  logic [7:0]  cmap_flag;
  logic [7:0]  img_type;
  logic [15:0] img_width;
  logic [15:0] img_height;
  logic [7:0]  pix_depth;
  logic [7:0]  skip_cnt;
  logic [7:0]  pkt_left;
  logic        pkt_is_run;
  logic [1:0]  pix_byte;
  logic [31:0] pix_color;
  logic [15:0] cur_col;
  logic [15:0] cur_row;

  run_t        pending_runs[$];
  logic [7:0]  file_q[$];
  int          fail_count;
  int          sent_bytes;
  int          burst_left;
  bit          hold_req;
  int          hold_left;
  int          rx_cycle;
  int          rx_mode;

  function automatic void clear_decoder();
    dec_phase  = PH_HEADER;
    hdr_idx    = '0;
    id_len     = '0;
    cmap_flag  = '0;
    img_type   = '0;
    img_width  = '0;
    img_height = '0;
    pix_depth  = '0;
    skip_cnt   = '0;
    pkt_left   = '0;
    pkt_is_run = 1'b0;
    pix_byte   = '0;
    pix_color  = '0;
    cur_col    = '0;
    cur_row    = '0;
  endfunction

  function automatic void start_pixels();
    pix_byte   = '0;
    pkt_left   = '0;
    pkt_is_run = 1'b0;
    dec_phase  = (img_type == TYPE_RLE) ? PH_PACKET : PH_PIXEL;
  endfunction

  function automatic run_t emit_run(input logic [7:0] n);
    run_t            r;
    longint unsigned w;
    longint unsigned remaining;
    longint unsigned cnt;
    longint unsigned pos;
    logic            done;
    w         = img_width;
    remaining = longint'(cur_row) * w + (w - cur_col);
    cnt       = n;
    if (cnt > remaining) cnt = remaining;
    done           = (cnt == remaining);
    r              = '0;
    r.kind         = KIND_RUN;
    r.error_code   = ERR_NONE;
    r.red          = pix_color[23:16];
    r.green        = pix_color[15:8];
    r.blue         = pix_color[7:0];
    r.alpha        = (pix_depth == DEPTH_24) ? ALPHA_OPAQUE : pix_color[31:24];
    r.start_column = cur_col;
    r.start_row    = cur_row;
    r.run_count    = cnt[7:0];
    r.image_done   = done;
    if (done) begin
      dec_phase = PH_STOP;
    end else begin
      pos     = longint'(cur_col) + cnt;
      cur_row = cur_row - 16'(pos / w);
      cur_col = 16'(pos % w);
    end
    return r;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic sof,
                                      output logic has_run, output run_t r);
    logic       bad_type;
    logic [1:0] last_byte;
    logic [7:0] n;
    has_run = 1'b0;
    r       = '0;
    if (sof) clear_decoder();
    case (dec_phase)
      PH_HEADER: begin
        case (hdr_idx)
          HDR_ID_LEN:    id_len = b;
          HDR_CMAP:      cmap_flag = b;
          HDR_TYPE:      img_type = b;
          HDR_WIDTH_LO:  img_width[7:0] = b;
          HDR_WIDTH_HI:  img_width[15:8] = b;
          HDR_HEIGHT_LO: img_height[7:0] = b;
          HDR_HEIGHT_HI: img_height[15:8] = b;
          HDR_DEPTH:     pix_depth = b;
          default: ;
        endcase
        hdr_idx = hdr_idx + 5'd1;
        if (hdr_idx > HDR_LAST) begin
          bad_type = (img_type != TYPE_RAW) && (img_type != TYPE_RLE);
          if (bad_type || cmap_flag != 8'd0 ||
              (pix_depth != DEPTH_24 && pix_depth != DEPTH_32)) begin
            has_run      = 1'b1;
            r.kind       = KIND_ERROR;
            r.error_code = bad_type ? ERR_TYPE : ERR_FORMAT;
            dec_phase    = PH_STOP;
          end else if (img_width == 16'd0 || img_height == 16'd0) begin
            dec_phase = PH_STOP;
          end else begin
            cur_row = img_height - 16'd1;
            cur_col = '0;
            if (id_len != 8'd0) begin
              skip_cnt  = id_len;
              dec_phase = PH_SKIP;
            end else begin
              start_pixels();
            end
          end
        end
      end
      PH_SKIP: begin
        skip_cnt = skip_cnt - 8'd1;
        if (skip_cnt == 8'd0) start_pixels();
      end
      PH_PACKET: begin
        pkt_left   = (b & RLE_COUNT_MASK) + 8'd1;
        pkt_is_run = b[7];
        pix_byte   = '0;
        dec_phase  = PH_PIXEL;
      end
      PH_PIXEL: begin
        last_byte = (pix_depth == DEPTH_32) ? 2'd3 : 2'd2;
        if (pix_byte == 2'd0) pix_color = '0;
        pix_color = pix_color | (32'(b) << (8 * pix_byte));
        if (pix_byte != last_byte) begin
          pix_byte = pix_byte + 2'd1;
        end else begin
          pix_byte = '0;
          n = 8'd1;
          if (img_type == TYPE_RLE) begin
            if (pkt_is_run) begin
              n        = pkt_left;
              pkt_left = '0;
            end else begin
              pkt_left = pkt_left - 8'd1;
            end
          end
          r       = emit_run(n);
          has_run = 1'b1;
          if (dec_phase != PH_STOP && img_type == TYPE_RLE && pkt_left == 8'd0)
            dec_phase = PH_PACKET;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic string run_str(input run_t r);
    return $sformatf("kind %0d err %0d rgba %02h%02h%02h%02h col %0d row %0d cnt %0d done %0d",
                     r.kind, r.error_code, r.red, r.green, r.blue, r.alpha,
                     r.start_column, r.start_row, r.run_count, r.image_done);
  endfunction

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // result checking and prediction on accepted transactions
  always @(posedge clk_i) begin
    run_t exp_run;
    run_t got_run;
    run_t new_run;
    logic has_run;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got_run = out_if.data;
        if (pending_runs.size() == 0) begin
          note_fail({"unexpected result: ", run_str(got_run)});
        end else begin
          exp_run = pending_runs.pop_front();
          if (got_run.kind !== exp_run.kind ||
              got_run.error_code !== exp_run.error_code ||
              got_run.red !== exp_run.red ||
              got_run.green !== exp_run.green ||
              got_run.blue !== exp_run.blue ||
              got_run.alpha !== exp_run.alpha ||
              got_run.start_column !== exp_run.start_column ||
              got_run.start_row !== exp_run.start_row ||
              got_run.run_count !== exp_run.run_count ||
              got_run.image_done !== exp_run.image_done)
            note_fail({"mismatch: expected ", run_str(exp_run),
                       " / actual ", run_str(got_run)});
        end
      end
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data.byte_value, in_if.data.start_of_file, has_run, new_run);
        if (has_run) pending_runs.push_back(new_run);
      end
    end
  end

  // receiver: stall pattern plus a long hold on request
  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= (rx_cycle % 4) != 0;
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] v, input bit sof);
    byte_t item;
    int    gap;
    item.byte_value    = v;
    item.start_of_file = sof;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_file(input bit with_sof);
    foreach (file_q[i]) send_byte(file_q[i], with_sof && i == 0);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic push_header(input logic [7:0] idl, input logic [7:0] cmap,
                             input logic [7:0] ftype, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth);
    file_q.delete();
    file_q.push_back(idl);
    file_q.push_back(cmap);
    file_q.push_back(ftype);
    repeat (9) file_q.push_back($urandom_range(0, 255));
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(h[15:8]);
    file_q.push_back(depth);
    file_q.push_back($urandom_range(0, 255));
    repeat (idl) file_q.push_back($urandom_range(0, 255));
  endtask

  task automatic push_pixel(input int bpp);
    repeat (bpp) file_q.push_back($urandom_range(0, 255));
  endtask

  task automatic push_junk(input int n);
    repeat (n) file_q.push_back($urandom_range(0, 255));
  endtask

  task automatic test_no_sof();
    push_header(8'd0, 8'd0, TYPE_RAW, 16'd2, 16'd2, DEPTH_24);
    repeat (4) push_pixel(3);
    push_junk(3);
    send_file(1'b0);
    wait_idle();
  endtask

  task automatic test_header_errors();
    push_header(8'd0, 8'd0, 8'd1, 16'd2, 16'd2, DEPTH_24);
    push_junk(3);
    send_file(1'b1);
    push_header(8'd0, 8'd1, TYPE_RLE, 16'd2, 16'd2, DEPTH_32);
    push_junk(3);
    send_file(1'b1);
    push_header(8'd0, 8'd0, TYPE_RAW, 16'd2, 16'd2, 8'd8);
    push_junk(3);
    send_file(1'b1);
    // bad type wins over colormap and depth
    push_header(8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 8'd0);
    push_junk(3);
    send_file(1'b1);
    push_header(8'd0, 8'd0, TYPE_RAW, 16'd3, 16'd1, 8'd16);
    send_file(1'b1);
    wait_idle();
  endtask

  task automatic test_empty_image();
    push_header(8'd0, 8'd0, TYPE_RAW, 16'd0, 16'd7, DEPTH_24);
    push_junk(6);
    send_file(1'b1);
    push_header(8'd3, 8'd0, TYPE_RLE, 16'd5, 16'd0, DEPTH_32);
    push_junk(6);
    send_file(1'b1);
    wait_idle();
  endtask

  task automatic test_extremes();
    push_header(8'd255, 8'd0, TYPE_RAW, 16'hffff, 16'hffff, DEPTH_32);
    repeat (4) file_q.push_back(8'h00);
    repeat (4) file_q.push_back(8'hff);
    repeat (3) push_pixel(4);
    send_file(1'b1);
    push_header(8'd0, 8'd0, TYPE_RLE, 16'hff00, 16'h8000, DEPTH_24);
    file_q.push_back(8'hff);
    push_pixel(3);
    file_q.push_back(8'h7f);
    repeat (128) push_pixel(3);
    file_q.push_back(8'h80);
    push_pixel(3);
    file_q.push_back(8'h00);
    push_pixel(3);
    send_file(1'b1);
    wait_idle();
  endtask

  task automatic test_clipping();
    // run packet far longer than the image
    push_header(8'd0, 8'd0, TYPE_RLE, 16'd3, 16'd2, DEPTH_24);
    file_q.push_back(8'hff);
    push_pixel(3);
    push_junk(4);
    send_file(1'b1);
    // raw packet that runs past the last pixel
    push_header(8'd1, 8'd0, TYPE_RLE, 16'd2, 16'd2, DEPTH_32);
    file_q.push_back(8'h01);
    repeat (2) push_pixel(4);
    file_q.push_back(8'h05);
    repeat (6) push_pixel(4);
    send_file(1'b1);
    // runs wrapping rows, final run clipped
    push_header(8'd0, 8'd0, TYPE_RLE, 16'd4, 16'd3, DEPTH_24);
    file_q.push_back(8'h86);
    push_pixel(3);
    file_q.push_back(8'h01);
    repeat (2) push_pixel(3);
    file_q.push_back(8'h83);
    push_pixel(3);
    send_file(1'b1);
    // uncompressed image with trailing pixels
    push_header(8'd0, 8'd0, TYPE_RAW, 16'd1, 16'd3, DEPTH_24);
    repeat (5) push_pixel(3);
    send_file(1'b1);
    wait_idle();
  endtask

  task automatic test_restart();
    push_header(8'd0, 8'd0, TYPE_RAW, 16'd4, 16'd4, DEPTH_24);
    while (file_q.size() > 23) void'(file_q.pop_back());
    send_file(1'b1);
    push_header(8'd0, 8'd0, TYPE_RLE, 16'd2, 16'd2, DEPTH_24);
    while (file_q.size() > 10) void'(file_q.pop_back());
    send_file(1'b1);
    push_header(8'd2, 8'd0, TYPE_RAW, 16'd2, 16'd1, DEPTH_32);
    repeat (2) push_pixel(4);
    send_file(1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    push_header(8'd0, 8'd0, TYPE_RAW, 16'd16, 16'd4, DEPTH_24);
    repeat (64) push_pixel(3);
    send_file(1'b1);
    wait_idle();
  endtask

  task automatic random_file();
    int         sel;
    int         bpp;
    int         w;
    int         h;
    longint     left;
    int         cnt;
    int         cut;
    bit         is_run;
    logic [7:0] ftype;
    logic [7:0] depth;
    logic [7:0] idl;
    logic [7:0] bad_depth;
    sel   = $urandom_range(0, 99);
    ftype = $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
    depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
    bpp   = (depth == DEPTH_32) ? 4 : 3;
    idl   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 12)) : 8'd0;
    if (sel < 80) begin
      if ($urandom_range(0, 19) == 0) begin
        w = $urandom_range(1, 65535);
        h = $urandom_range(1, 65535);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
      end
      push_header(idl, 8'd0, ftype, 16'(w), 16'(h), depth);
      left = longint'(w) * h;
      if (left > 40) left = 40;
      if (ftype == TYPE_RAW) begin
        repeat (left) push_pixel(bpp);
      end else begin
        while (left > 0) begin
          cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128)
                                            : $urandom_range(1, (left < 128) ? left : 128);
          is_run = $urandom_range(0, 1);
          file_q.push_back({is_run, 7'(cnt - 1)});
          if (is_run) push_pixel(bpp);
          else repeat (cnt) push_pixel(bpp);
          left = (cnt >= left) ? 0 : left - cnt;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, file_q.size() - 1);
        while (file_q.size() > cut) void'(file_q.pop_back());
      end else if ($urandom_range(0, 9) == 0) begin
        push_junk($urandom_range(1, 6));
      end
    end else if (sel < 88) begin
      case ($urandom_range(0, 3))
        0: bad_depth = 8'd8;
        1: bad_depth = 8'd16;
        2: bad_depth = $urandom_range(0, 255);
        default: bad_depth = depth;
      endcase
      push_header(idl, $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'd0,
                  ($urandom_range(0, 3) == 0) ? ftype : 8'($urandom_range(0, 255)),
                  16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)), bad_depth);
      push_junk($urandom_range(0, 4));
    end else if (sel < 94) begin
      if ($urandom_range(0, 1))
        push_header(idl, 8'd0, ftype, 16'd0, 16'($urandom_range(0, 65535)), depth);
      else
        push_header(idl, 8'd0, ftype, 16'($urandom_range(1, 65535)), 16'd0, depth);
      push_junk($urandom_range(0, 4));
    end else begin
      file_q.delete();
      push_junk($urandom_range(5, 40));
    end
    send_file(1'b1);
  endtask

  task automatic test_random();
    int first;
    first = sent_bytes;
    while (sent_bytes - first < 150) begin
      random_file();
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    fail_count   = 0;
    sent_bytes   = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    hold_left    = 0;
    rx_cycle     = 0;
    rx_mode      = 0;
    clear_decoder();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_sof();
    test_header_errors();
    test_empty_image();
    test_extremes();
    test_clipping();
    test_restart();
    test_backpressure();
    test_random();
    if (fail_count == 0 && pending_runs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
